### rtl/doubly_linked_list_cursor_unit_defines.svh
// Assertion macros for the doubly linked list cursor unit checker
`ifndef DOUBLY_LINKED_LIST_CURSOR_UNIT_DEFINES_SVH
`define DOUBLY_LINKED_LIST_CURSOR_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define DLLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dllc check failed");

// next-cycle implication, reset masks the check
`define DLLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dllc check failed");

`endif

### rtl/dllc_pkg.sv
// Command and status codes of the doubly linked list cursor unit
`default_nettype none
package dllc_pkg;

  localparam int unsigned FuncWidth = 5;
  localparam int unsigned IoWidth   = 32;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_CLEAR      = 5'd0,
    FUNC_INS_FIRST  = 5'd1,
    FUNC_INS_LAST   = 5'd2,
    FUNC_CUR_FIRST  = 5'd3,
    FUNC_CUR_LAST   = 5'd4,
    FUNC_RD_FIRST   = 5'd5,
    FUNC_RD_LAST    = 5'd6,
    FUNC_DEL_FIRST  = 5'd7,
    FUNC_DEL_LAST   = 5'd8,
    FUNC_DEL_AFTER  = 5'd9,
    FUNC_DEL_BEFORE = 5'd10,
    FUNC_INS_AFTER  = 5'd11,
    FUNC_INS_BEFORE = 5'd12,
    FUNC_RD_ACTIVE  = 5'd13,
    FUNC_WR_ACTIVE  = 5'd14,
    FUNC_NEXT       = 5'd15,
    FUNC_PREV       = 5'd16,
    FUNC_QUERY      = 5'd17
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage
`default_nettype wire

### rtl/dllc_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module dllc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/doubly_linked_list_cursor_unit.sv
// Doubly linked list with cursor, node pool in registers and a value RAM
//
//  channel  | handshake       | payload
//  ---------+-----------------+--------------------------------------------
//  command  | start_i, busy_o | func_i, value_in_i
//  result   | done_o          | value_out_o, value_valid_o, active_o, status_o
//
// One command per cycle: busy_o stays low, and the result of a command
// accepted at one edge is shown with done_o for the following cycle.
// The set of links, ends and cursor updates in a single pass; values sit in
// a RAM whose registered read port lines up with the result register.
// Reset empties the list at once (used map, ends and cursor); no clear sweep.
// Results cannot be stalled, so nothing backs up into the command side.
`default_nettype none
module doubly_linked_list_cursor_unit #(
  parameter int unsigned NODES      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [dllc_pkg::FuncWidth-1:0]      func_i,
  input  wire logic signed [dllc_pkg::IoWidth-1:0] value_in_i,
  output logic                                     done_o,
  output logic signed [dllc_pkg::IoWidth-1:0]      value_out_o,
  output logic                                     value_valid_o,
  output logic                                     active_o,
  output logic [1:0]                               status_o
);

  import dllc_pkg::*;

  localparam int unsigned PW = $clog2(NODES + 1);
  localparam int unsigned AW = $clog2(NODES);

  typedef logic [PW-1:0] ptr_t;
  typedef logic [AW-1:0] addr_t;

  localparam ptr_t NONE = PW'(NODES);

  // list state
  ptr_t             head_q, head_d;
  ptr_t             tail_q, tail_d;
  ptr_t             cur_q, cur_d;
  logic [NODES-1:0] used_q, used_d;
  ptr_t             next_q [NODES];
  ptr_t             prev_q [NODES];

  // result state
  logic    done_q;
  logic    rd_ok_q, rd_ok_d;
  logic    active_q;
  status_e status_q, status_d;

  // two write ports on each link array
  logic  [1:0] nx_we, pv_we;
  addr_t       nx_wa [2];
  addr_t       pv_wa [2];
  ptr_t        nx_wd [2];
  ptr_t        pv_wd [2];

  // value RAM ports
  logic                  val_we;
  addr_t                 val_wa;
  logic [DATA_WIDTH-1:0] val_wd;
  logic                  val_re;
  ptr_t                  val_ra;
  logic [DATA_WIDTH-1:0] val_rd;

  logic  accept;
  ptr_t  c_nx, c_pv, c_nx2, c_pv2, h_nx, t_pv;
  ptr_t  free_idx;
  logic  free_ok;
  addr_t free_a;

  function automatic logic is_node(ptr_t p);
    return p < NONE;
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i;

  assign c_nx  = next_q[cur_q[AW-1:0]];
  assign c_pv  = prev_q[cur_q[AW-1:0]];
  assign c_nx2 = next_q[c_nx[AW-1:0]];
  assign c_pv2 = prev_q[c_pv[AW-1:0]];
  assign h_nx  = next_q[head_q[AW-1:0]];
  assign t_pv  = prev_q[tail_q[AW-1:0]];

  // lowest free slot
  always_comb begin
    free_idx = NONE;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = PW'(i);
      end
    end
  end
  assign free_ok = ~&used_q;
  assign free_a  = free_idx[AW-1:0];

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cur_d    = cur_q;
    used_d   = used_q;
    nx_we    = '0;
    pv_we    = '0;
    nx_wa[0] = free_a;
    nx_wa[1] = free_a;
    pv_wa[0] = free_a;
    pv_wa[1] = free_a;
    nx_wd[0] = NONE;
    nx_wd[1] = NONE;
    pv_wd[0] = NONE;
    pv_wd[1] = NONE;
    val_we   = 1'b0;
    val_wa   = free_a;
    val_wd   = DATA_WIDTH'(value_in_i);
    val_re   = 1'b0;
    val_ra   = cur_q;
    rd_ok_d  = 1'b0;
    status_d = STATUS_OK;

    if (accept) begin
      unique case (func_i)
        FUNC_CLEAR: begin
          used_d = '0;
          head_d = NONE;
          tail_d = NONE;
          cur_d  = NONE;
        end
        FUNC_INS_FIRST: begin
          if (!free_ok) begin
            status_d = STATUS_FULL;
          end else begin
            used_d[free_a] = 1'b1;
            val_we         = 1'b1;
            nx_we[0]       = 1'b1;
            nx_wd[0]       = head_q;
            pv_we[0]       = 1'b1;
            pv_wd[0]       = NONE;
            if (is_node(head_q)) begin
              pv_we[1] = 1'b1;
              pv_wa[1] = head_q[AW-1:0];
              pv_wd[1] = free_idx;
            end else begin
              tail_d = free_idx;
            end
            head_d = free_idx;
          end
        end
        FUNC_INS_LAST: begin
          if (!free_ok) begin
            status_d = STATUS_FULL;
          end else begin
            used_d[free_a] = 1'b1;
            val_we         = 1'b1;
            pv_we[0]       = 1'b1;
            pv_wd[0]       = tail_q;
            nx_we[0]       = 1'b1;
            nx_wd[0]       = NONE;
            if (is_node(tail_q)) begin
              nx_we[1] = 1'b1;
              nx_wa[1] = tail_q[AW-1:0];
              nx_wd[1] = free_idx;
            end else begin
              head_d = free_idx;
            end
            tail_d = free_idx;
          end
        end
        FUNC_CUR_FIRST: cur_d = head_q;
        FUNC_CUR_LAST:  cur_d = tail_q;
        FUNC_RD_FIRST, FUNC_RD_LAST, FUNC_RD_ACTIVE: begin
          if (func_i == FUNC_RD_FIRST) begin
            val_ra = head_q;
          end else if (func_i == FUNC_RD_LAST) begin
            val_ra = tail_q;
          end
          if (is_node(val_ra)) begin
            val_re  = 1'b1;
            rd_ok_d = 1'b1;
          end else begin
            status_d = STATUS_EMPTY;
          end
        end
        FUNC_DEL_FIRST: begin
          if (is_node(head_q)) begin
            head_d = h_nx;
            if (is_node(h_nx)) begin
              pv_we[0] = 1'b1;
              pv_wa[0] = h_nx[AW-1:0];
              pv_wd[0] = NONE;
            end else begin
              tail_d = NONE;
            end
            used_d[head_q[AW-1:0]] = 1'b0;
            if (cur_q == head_q) begin
              cur_d = NONE;
            end
          end
        end
        FUNC_DEL_LAST: begin
          if (is_node(tail_q)) begin
            tail_d = t_pv;
            if (is_node(t_pv)) begin
              nx_we[0] = 1'b1;
              nx_wa[0] = t_pv[AW-1:0];
              nx_wd[0] = NONE;
            end else begin
              head_d = NONE;
            end
            used_d[tail_q[AW-1:0]] = 1'b0;
            if (cur_q == tail_q) begin
              cur_d = NONE;
            end
          end
        end
        FUNC_DEL_AFTER: begin
          if (is_node(cur_q) && is_node(c_nx)) begin
            nx_we[0] = 1'b1;
            nx_wa[0] = cur_q[AW-1:0];
            nx_wd[0] = c_nx2;
            if (is_node(c_nx2)) begin
              pv_we[0] = 1'b1;
              pv_wa[0] = c_nx2[AW-1:0];
              pv_wd[0] = cur_q;
            end else begin
              tail_d = cur_q;
            end
            used_d[c_nx[AW-1:0]] = 1'b0;
          end
        end
        FUNC_DEL_BEFORE: begin
          if (is_node(cur_q) && is_node(c_pv)) begin
            pv_we[0] = 1'b1;
            pv_wa[0] = cur_q[AW-1:0];
            pv_wd[0] = c_pv2;
            if (is_node(c_pv2)) begin
              nx_we[0] = 1'b1;
              nx_wa[0] = c_pv2[AW-1:0];
              nx_wd[0] = cur_q;
            end else begin
              head_d = cur_q;
            end
            used_d[c_pv[AW-1:0]] = 1'b0;
          end
        end
        FUNC_INS_AFTER: begin
          if (is_node(cur_q)) begin
            if (!free_ok) begin
              status_d = STATUS_FULL;
            end else begin
              used_d[free_a] = 1'b1;
              val_we         = 1'b1;
              nx_we[0]       = 1'b1;
              nx_wd[0]       = c_nx;
              pv_we[0]       = 1'b1;
              pv_wd[0]       = cur_q;
              if (is_node(c_nx)) begin
                pv_we[1] = 1'b1;
                pv_wa[1] = c_nx[AW-1:0];
                pv_wd[1] = free_idx;
              end else begin
                tail_d = free_idx;
              end
              nx_we[1] = 1'b1;
              nx_wa[1] = cur_q[AW-1:0];
              nx_wd[1] = free_idx;
            end
          end
        end
        FUNC_INS_BEFORE: begin
          if (is_node(cur_q)) begin
            if (!free_ok) begin
              status_d = STATUS_FULL;
            end else begin
              used_d[free_a] = 1'b1;
              val_we         = 1'b1;
              pv_we[0]       = 1'b1;
              pv_wd[0]       = c_pv;
              nx_we[0]       = 1'b1;
              nx_wd[0]       = cur_q;
              if (is_node(c_pv)) begin
                nx_we[1] = 1'b1;
                nx_wa[1] = c_pv[AW-1:0];
                nx_wd[1] = free_idx;
              end else begin
                head_d = free_idx;
              end
              pv_we[1] = 1'b1;
              pv_wa[1] = cur_q[AW-1:0];
              pv_wd[1] = free_idx;
            end
          end
        end
        FUNC_WR_ACTIVE: begin
          if (is_node(cur_q)) begin
            val_we = 1'b1;
            val_wa = cur_q[AW-1:0];
          end
        end
        FUNC_NEXT: begin
          if (is_node(cur_q)) begin
            cur_d = c_nx;
          end
        end
        FUNC_PREV: begin
          if (is_node(cur_q)) begin
            cur_d = c_pv;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= NONE;
      tail_q   <= NONE;
      cur_q    <= NONE;
      used_q   <= '0;
      done_q   <= 1'b0;
      rd_ok_q  <= 1'b0;
      active_q <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      used_q   <= used_d;
      done_q   <= accept;
      if (accept) begin
        rd_ok_q  <= rd_ok_d;
        active_q <= is_node(cur_d);
        status_q <= status_d;
      end
    end
  end

  // links of unused nodes are never read, so the arrays need no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NODES; i++) begin
      for (int p = 0; p < 2; p++) begin
        if (nx_we[p] && nx_wa[p] == AW'(i)) begin
          next_q[i] <= nx_wd[p];
        end
        if (pv_we[p] && pv_wa[p] == AW'(i)) begin
          prev_q[i] <= pv_wd[p];
        end
      end
    end
  end

  dllc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NODES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_wa),
    .wdata_i (val_wd),
    .re_i    (val_re),
    .raddr_i (val_ra[AW-1:0]),
    .rdata_o (val_rd)
  );

  assign done_o        = done_q;
  assign value_valid_o = rd_ok_q;
  assign value_out_o   = rd_ok_q ? IoWidth'($signed(val_rd)) : '0;
  assign active_o      = active_q;
  assign status_o      = status_q;

endmodule
`default_nettype wire

### rtl/dllc_checker.sv
// Port-level checker for the doubly linked list cursor unit, with its bind
`default_nettype none
`include "doubly_linked_list_cursor_unit_defines.svh"
module dllc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic                                busy_o,
  input wire logic [dllc_pkg::FuncWidth-1:0]      func_i,
  input wire logic                                done_o,
  input wire logic signed [dllc_pkg::IoWidth-1:0] value_out_o,
  input wire logic                                value_valid_o,
  input wire logic                                active_o,
  input wire logic [1:0]                          status_o
);

  import dllc_pkg::*;

  // every accepted item gives its result in the next cycle, and only then
  `DLLC_ASSERT_NEXT(a_result_follows, start_i && !busy_o, done_o)
  `DLLC_ASSERT_NEXT(a_no_stray_result, !(start_i && !busy_o), !done_o)
  // a read that delivers a value is never flagged
  `DLLC_ASSERT_NOW(a_read_ok, done_o && value_valid_o, status_o == STATUS_OK)
  `DLLC_ASSERT_NOW(a_zero_when_no_read, done_o && !value_valid_o, value_out_o == '0)
  // clearing the list always drops the cursor
  `DLLC_ASSERT_NEXT(a_clear_drops_cursor, start_i && !busy_o && func_i == FUNC_CLEAR, !active_o)

endmodule

bind doubly_linked_list_cursor_unit dllc_checker u_dllc_checker (.*);
`default_nettype wire

### tb/tb_doubly_linked_list_cursor_unit.sv
// Testbench for the doubly linked list cursor unit: directed and random commands vs a predictor
`timescale 1ns / 1ps
module tb_doubly_linked_list_cursor_unit;
  import dllc_pkg::*;

  localparam int unsigned NODES = 16;
  localparam logic [4:0] NIL = 5'(NODES);
  localparam logic [FuncWidth-1:0] FUNC_SPARE_LOW = 5'd18;
  localparam logic [FuncWidth-1:0] FUNC_SPARE_TOP = 5'd31;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [IoWidth-1:0] value;
    logic               valid;
    logic               active;
    status_e            status;
  } list_resp_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  logic [FuncWidth-1:0]       func_i = '0;
  logic signed [IoWidth-1:0]  value_in_i = '0;
  logic                       done_o;
  logic signed [IoWidth-1:0]  value_out_o;
  logic                       value_valid_o;
  logic                       active_o;
  logic [1:0]                 status_o;

  doubly_linked_list_cursor_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .value_in_i   (value_in_i),
    .done_o       (done_o),
    .value_out_o  (value_out_o),
    .value_valid_o(value_valid_o),
    .active_o     (active_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the node pool, list ends and cursor
  logic [IoWidth-1:0] node_val [NODES];
  logic [4:0]         link_nxt [NODES];
  logic [4:0]         link_prv [NODES];
  logic [NODES-1:0]   slot_used = '0;
  logic [4:0]         head_at = NIL;
  logic [4:0]         tail_at = NIL;
  logic [4:0]         cursor_at = NIL;

  list_resp_t  resp_due_q [$];
  int          err_count = 0;
  int          quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned items_sent = 0;

  function automatic logic is_node(input logic [4:0] idx);
    return idx < NIL;
  endfunction

  function automatic logic [4:0] free_slot();
    for (int i = 0; i < NODES; i++) begin
      if (!slot_used[i]) return 5'(i);
    end
    return NIL;
  endfunction

  function automatic void drop_node(input logic [4:0] n);
    if (is_node(n)) slot_used[n[3:0]] = 1'b0;
    if (cursor_at == n) cursor_at = NIL;
  endfunction

  function automatic void put_node(input logic [4:0] n, input logic [IoWidth-1:0] v,
                                   input logic [4:0] p, input logic [4:0] q);
    slot_used[n[3:0]] = 1'b1;
    node_val[n[3:0]]  = v;
    link_prv[n[3:0]]  = p;
    link_nxt[n[3:0]]  = q;
  endfunction

  // runs one command on the shadow list and returns the result it must give
  function automatic list_resp_t list_apply(input logic [FuncWidth-1:0] cmd,
                                            input logic [IoWidth-1:0] v);
    list_resp_t r;
    logic [4:0] c, n, t, u;
    r = '{value: '0, valid: 1'b0, active: 1'b0, status: STATUS_OK};
    c = cursor_at;
    case (cmd)
      FUNC_CLEAR: begin
        slot_used = '0;
        head_at = NIL;
        tail_at = NIL;
        cursor_at = NIL;
      end
      FUNC_INS_FIRST, FUNC_INS_LAST: begin
        n = free_slot();
        if (!is_node(n)) begin
          r.status = STATUS_FULL;
        end else if (cmd == FUNC_INS_FIRST) begin
          put_node(n, v, NIL, head_at);
          if (is_node(head_at)) link_prv[head_at[3:0]] = n;
          else tail_at = n;
          head_at = n;
        end else begin
          put_node(n, v, tail_at, NIL);
          if (is_node(tail_at)) link_nxt[tail_at[3:0]] = n;
          else head_at = n;
          tail_at = n;
        end
      end
      FUNC_CUR_FIRST: cursor_at = head_at;
      FUNC_CUR_LAST:  cursor_at = tail_at;
      FUNC_RD_FIRST, FUNC_RD_LAST, FUNC_RD_ACTIVE: begin
        t = (cmd == FUNC_RD_FIRST) ? head_at : (cmd == FUNC_RD_LAST) ? tail_at : c;
        if (is_node(t)) begin
          r.value = node_val[t[3:0]];
          r.valid = 1'b1;
        end else begin
          r.status = STATUS_EMPTY;
        end
      end
      FUNC_DEL_FIRST: begin
        t = head_at;
        if (is_node(t)) begin
          u = link_nxt[t[3:0]];
          head_at = u;
          if (is_node(u)) link_prv[u[3:0]] = NIL;
          else tail_at = NIL;
          drop_node(t);
        end
      end
      FUNC_DEL_LAST: begin
        t = tail_at;
        if (is_node(t)) begin
          u = link_prv[t[3:0]];
          tail_at = u;
          if (is_node(u)) link_nxt[u[3:0]] = NIL;
          else head_at = NIL;
          drop_node(t);
        end
      end
      FUNC_DEL_AFTER: begin
        if (is_node(c) && is_node(link_nxt[c[3:0]])) begin
          t = link_nxt[c[3:0]];
          u = link_nxt[t[3:0]];
          link_nxt[c[3:0]] = u;
          if (is_node(u)) link_prv[u[3:0]] = c;
          else tail_at = c;
          drop_node(t);
        end
      end
      FUNC_DEL_BEFORE: begin
        if (is_node(c) && is_node(link_prv[c[3:0]])) begin
          t = link_prv[c[3:0]];
          u = link_prv[t[3:0]];
          link_prv[c[3:0]] = u;
          if (is_node(u)) link_nxt[u[3:0]] = c;
          else head_at = c;
          drop_node(t);
        end
      end
      FUNC_INS_AFTER, FUNC_INS_BEFORE: begin
        // inactive cursor wins over a full pool
        if (is_node(c)) begin
          n = free_slot();
          if (!is_node(n)) begin
            r.status = STATUS_FULL;
          end else if (cmd == FUNC_INS_AFTER) begin
            u = link_nxt[c[3:0]];
            put_node(n, v, c, u);
            if (is_node(u)) link_prv[u[3:0]] = n;
            else tail_at = n;
            link_nxt[c[3:0]] = n;
          end else begin
            u = link_prv[c[3:0]];
            put_node(n, v, u, c);
            if (is_node(u)) link_nxt[u[3:0]] = n;
            else head_at = n;
            link_prv[c[3:0]] = n;
          end
        end
      end
      FUNC_WR_ACTIVE: if (is_node(c)) node_val[c[3:0]] = v;
      FUNC_NEXT:      if (is_node(c)) cursor_at = link_nxt[c[3:0]];
      FUNC_PREV:      if (is_node(c)) cursor_at = link_prv[c[3:0]];
      default: ;
    endcase
    r.active = is_node(cursor_at);
    return r;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("%0t ERROR %s", $time, msg);
  endtask

  // result check, command capture and watchdog, all on the rising edge
  always @(posedge clk_i) begin
    list_resp_t exp_r;
    if (rst_ni) begin
      if (done_o) begin
        if (resp_due_q.size() == 0) begin
          report_error("result with no command outstanding");
        end else begin
          exp_r = resp_due_q.pop_front();
          if (value_out_o !== exp_r.value)
            report_error($sformatf("value_out %h, expected %h", value_out_o, exp_r.value));
          if (value_valid_o !== exp_r.valid)
            report_error($sformatf("value_valid %b, expected %b", value_valid_o, exp_r.valid));
          if (active_o !== exp_r.active)
            report_error($sformatf("active %b, expected %b", active_o, exp_r.active));
          if (status_o !== exp_r.status)
            report_error($sformatf("status %0d, expected %0d", status_o, exp_r.status));
        end
      end
      if (start_i && !busy_o) resp_due_q.push_back(list_apply(func_i, value_in_i));
    end
    if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // entered at a falling edge; returns at a falling edge after any sender gap
  task automatic issue_cmd(input logic [FuncWidth-1:0] cmd, input logic [IoWidth-1:0] v);
    start_i    = 1'b1;
    func_i     = cmd;
    value_in_i = v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic [IoWidth-1:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // weighted command pick that steers toward a live list and an active cursor
  function automatic logic [FuncWidth-1:0] pick_cmd();
    int unsigned roll;
    roll = $urandom_range(99);
    if (slot_used == '0 && $urandom_range(1) == 0)
      return $urandom_range(1) ? FUNC_INS_FIRST : FUNC_INS_LAST;
    if (!is_node(cursor_at) && $urandom_range(99) < 40)
      return $urandom_range(1) ? FUNC_CUR_FIRST : FUNC_CUR_LAST;
    if (roll < 2)  return FUNC_CLEAR;
    if (roll < 14) return $urandom_range(1) ? FUNC_INS_FIRST : FUNC_INS_LAST;
    if (roll < 24) return $urandom_range(1) ? FUNC_INS_AFTER : FUNC_INS_BEFORE;
    if (roll < 30) return $urandom_range(1) ? FUNC_CUR_FIRST : FUNC_CUR_LAST;
    if (roll < 40) begin
      case ($urandom_range(2))
        0:       return FUNC_RD_FIRST;
        1:       return FUNC_RD_LAST;
        default: return FUNC_RD_ACTIVE;
      endcase
    end
    if (roll < 50) return $urandom_range(1) ? FUNC_DEL_FIRST : FUNC_DEL_LAST;
    if (roll < 58) return $urandom_range(1) ? FUNC_DEL_AFTER : FUNC_DEL_BEFORE;
    if (roll < 65) return FUNC_WR_ACTIVE;
    if (roll < 82) return $urandom_range(1) ? FUNC_NEXT : FUNC_PREV;
    if (roll < 86) return FUNC_QUERY;
    return FuncWidth'($urandom_range(31));
  endfunction

  task automatic test_empty_list();
    issue_cmd(FUNC_CLEAR, 32'h0);
    issue_cmd(FUNC_QUERY, 32'h0);
    issue_cmd(FUNC_RD_FIRST, 32'h0);
    issue_cmd(FUNC_RD_LAST, 32'h0);
    issue_cmd(FUNC_RD_ACTIVE, 32'h0);
    issue_cmd(FUNC_DEL_FIRST, 32'h0);
    issue_cmd(FUNC_DEL_LAST, 32'h0);
    issue_cmd(FUNC_CUR_FIRST, 32'h0);
    issue_cmd(FUNC_NEXT, 32'h0);
    issue_cmd(FUNC_INS_BEFORE, 32'h1234_5678);
    issue_cmd(FUNC_WR_ACTIVE, 32'hFFFF_FFFF);
    issue_cmd(FUNC_SPARE_TOP, 32'hFFFF_FFFF);
  endtask

  task automatic test_single_node();
    issue_cmd(FUNC_INS_FIRST, 32'h8000_0000);
    issue_cmd(FUNC_CUR_LAST, 32'h0);
    issue_cmd(FUNC_DEL_LAST, 32'h0);
    issue_cmd(FUNC_RD_FIRST, 32'h0);
  endtask

  task automatic test_cursor_edits();
    issue_cmd(FUNC_INS_LAST, 32'h7FFF_FFFF);
    issue_cmd(FUNC_INS_FIRST, 32'hFFFF_FFFF);
    issue_cmd(FUNC_CUR_LAST, 32'h0);
    issue_cmd(FUNC_INS_AFTER, 32'h0000_0001);   // new tail
    issue_cmd(FUNC_PREV, 32'h0);
    issue_cmd(FUNC_INS_BEFORE, 32'h5555_5555);  // new head
    issue_cmd(FUNC_DEL_BEFORE, 32'h0);          // head goes, cursor becomes head
    issue_cmd(FUNC_DEL_BEFORE, 32'h0);
    issue_cmd(FUNC_WR_ACTIVE, 32'hAAAA_AAAA);
    issue_cmd(FUNC_RD_FIRST, 32'h0);
    issue_cmd(FUNC_DEL_AFTER, 32'h0);
    issue_cmd(FUNC_RD_ACTIVE, 32'h0);
  endtask

  task automatic test_cursor_walk();
    issue_cmd(FUNC_CUR_LAST, 32'h0);
    issue_cmd(FUNC_DEL_AFTER, 32'h0);           // nothing after the tail
    issue_cmd(FUNC_NEXT, 32'h0);                // walks off the tail
    issue_cmd(FUNC_CUR_FIRST, 32'h0);
    issue_cmd(FUNC_PREV, 32'h0);                // walks off the head
    issue_cmd(FUNC_CUR_FIRST, 32'h0);
    issue_cmd(FUNC_DEL_FIRST, 32'h0);           // node under the cursor goes
    issue_cmd(FUNC_QUERY, 32'h0);
    issue_cmd(FUNC_RD_LAST, 32'h0);
    issue_cmd(FUNC_SPARE_LOW, 32'h0);
  endtask

  // fills the pool with random inserts, then hits the full pool from every side
  task automatic test_pool_full();
    logic [FuncWidth-1:0] cmd;
    int unsigned          tries;
    tries = 0;
    issue_cmd(FUNC_CLEAR, rand_word());
    while (slot_used != '1 && tries < 4 * NODES) begin
      tries++;
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(2))
          0:       cmd = FUNC_CUR_FIRST;
          1:       cmd = FUNC_CUR_LAST;
          default: cmd = FUNC_PREV;
        endcase
        issue_cmd(cmd, rand_word());
      end
      case ($urandom_range(3))
        0:       cmd = FUNC_INS_FIRST;
        1:       cmd = FUNC_INS_LAST;
        2:       cmd = FUNC_INS_AFTER;
        default: cmd = FUNC_INS_BEFORE;
      endcase
      issue_cmd(cmd, rand_word());
    end
    issue_cmd(FUNC_INS_FIRST, rand_word());
    issue_cmd(FUNC_INS_LAST, rand_word());
    issue_cmd(FUNC_CUR_LAST, rand_word());
    issue_cmd($urandom_range(1) ? FUNC_INS_AFTER : FUNC_INS_BEFORE, rand_word());
    issue_cmd(FUNC_NEXT, rand_word());
    // full pool, inactive cursor: still ok
    issue_cmd($urandom_range(1) ? FUNC_INS_AFTER : FUNC_INS_BEFORE, rand_word());
    issue_cmd(FUNC_RD_LAST, rand_word());
  endtask

  // runs until n_items more items have gone out, pool fills included
  task automatic test_random_traffic(input int unsigned n_items);
    logic [FuncWidth-1:0] cmd;
    int unsigned          stop_at;
    stop_at = items_sent + n_items;
    test_pool_full();
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 3) test_pool_full();
      cmd = pick_cmd();
      issue_cmd(cmd, rand_word());
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    sender_idle_pct = 8;
    test_empty_list();
    test_single_node();
    test_cursor_edits();
    test_cursor_walk();
    test_random_traffic(450);
    sender_idle_pct = 71;
    test_random_traffic(450);
    sender_idle_pct = 0;
    test_random_traffic(450);
    start_i = 1'b0;
    while (resp_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dllc_pkg.sv
rtl/dllc_ram.sv
rtl/doubly_linked_list_cursor_unit.sv
rtl/dllc_checker.sv
tb/tb_doubly_linked_list_cursor_unit.sv
